### design/gsps_pkg.sv
// shared types and constants for the gas sensor poll sequencer
// no dependencies; imported by every module of the block

package gsps_pkg;

    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 104;
    localparam int CFG_ADDR_W = 3;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_START_ADDR  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MODE_ADDR   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MODE_VALUE  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_RESULT_ADDR = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_ERR_MASK    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_RDY_MASK    = 3'd5;

    // configuration reset values
    localparam logic [7:0] START_ADDR_RST  = 8'hF4;
    localparam logic [7:0] MODE_ADDR_RST   = 8'h01;
    localparam logic [7:0] MODE_VALUE_RST  = 8'h10;
    localparam logic [7:0] RESULT_ADDR_RST = 8'h02;
    localparam logic [7:0] ERR_MASK_RST    = 8'h01;
    localparam logic [7:0] RDY_MASK_RST    = 8'h08;

    // input item kinds and transfer outcomes
    localparam logic       OP_TICK   = 1'b0;
    localparam logic       OP_DONE   = 1'b1;
    localparam logic [1:0] XFER_OK   = 2'd1;
    localparam logic [1:0] XFER_FAIL = 2'd2;

    localparam logic [3:0] RESULT_BLOCK_LEN = 4'd8;

    // resistance = RES_NUM * adc / (1023 * current)
    localparam int         DVD_W    = 31;
    localparam int         DVS_W    = 16;
    localparam int         QUO_W    = 21;
    localparam logic [QUO_W-1:0] RES_NUM = 21'd1650000;
    localparam logic [QUO_W-1:0] RES_SAT = 21'h1FFFFF;
    localparam logic [4:0] DIV_STEPS = 5'd31;

    typedef enum logic [1:0] {
        TX_NONE  = 2'd0,
        TX_START = 2'd1,
        TX_MODE  = 2'd2,
        TX_READ  = 2'd3
    } tx_kind_t;

    typedef struct packed {
        logic     accept;
        tx_kind_t tx_kind;
        logic     new_data;
        logic     in_error;
        logic     latch_status;
        logic     latch_meas;
        logic     mul_en;
        logic     div_start;
        logic     res_load;
        logic     out_load;
    } gsps_cmd_t;

    typedef struct packed {
        logic err_hit;
        logic rdy_hit;
        logic div_done;
        logic out_free;
    } gsps_stat_t;

endpackage

### design/gsps_div.sv
// restoring divider, one quotient bit per cycle
// depends on gsps_pkg

module gsps_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [gsps_pkg::DVD_W-1:0] dividend,
    input  logic [gsps_pkg::DVS_W-1:0] divisor,
    output logic                      done,
    output logic [gsps_pkg::QUO_W-1:0] quotient
);
    import gsps_pkg::*;

    logic             busy_reg;
    logic             done_reg;
    logic [4:0]       cnt_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;

    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   rem_diff;
    logic             fits;

    assign rem_sh   = {rem_reg, dvd_reg[DVD_W-1]};
    assign fits     = rem_sh >= {1'b0, dvs_reg};
    assign rem_diff = rem_sh - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 5'd1) && !start;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_STEPS;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // quotient bits shift in behind the dividend bits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], fits};
            rem_reg <= fits ? rem_diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg[QUO_W-1:0];

endmodule

### design/gsps_dp.sv
// datapath: configuration registers, latched measurement, resistance math, output register
// depends on gsps_pkg and gsps_div

module gsps_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic [gsps_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [7:0]                         cfg_data,
    input  logic [gsps_pkg::S_TDATA_W-1:0]     s_tdata,
    input  gsps_pkg::gsps_cmd_t                cmd,
    output gsps_pkg::gsps_stat_t               stat,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [gsps_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tuser
);
    import gsps_pkg::*;

    logic [7:0] start_addr_reg, mode_addr_reg, mode_value_reg, result_addr_reg;
    logic [7:0] err_mask_reg, rdy_mask_reg;

    logic [15:0]      eco2_reg, tvoc_reg;
    logic [5:0]       cur_reg;
    logic [9:0]       adc_reg;
    logic [QUO_W-1:0] res_reg;
    logic [7:0]       status_reg;

    logic [1:0]       p_tx_len_reg;
    logic [7:0]       p_tx_reg_reg, p_tx_data_reg;
    logic [3:0]       p_rx_len_reg;
    logic             p_new_reg, p_err_reg;
    logic [1:0]       p_tx_len_next;
    logic [7:0]       p_tx_reg_next, p_tx_data_next;
    logic [3:0]       p_rx_len_next;

    logic [DVD_W-1:0] prod_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic             div_done;
    logic [QUO_W-1:0] quot;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;

    logic [15:0] in_eco2, in_tvoc, in_raw;
    logic [7:0]  in_status;

    assign in_eco2   = s_tdata[17:2];
    assign in_tvoc   = s_tdata[33:18];
    assign in_status = s_tdata[41:34];
    assign in_raw    = s_tdata[57:42];

    assign stat.err_hit  = (in_status & err_mask_reg) != 8'd0;
    assign stat.rdy_hit  = (in_status & rdy_mask_reg) != 8'd0;
    assign stat.div_done = div_done;
    assign stat.out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_addr_reg  <= START_ADDR_RST;
            mode_addr_reg   <= MODE_ADDR_RST;
            mode_value_reg  <= MODE_VALUE_RST;
            result_addr_reg <= RESULT_ADDR_RST;
            err_mask_reg    <= ERR_MASK_RST;
            rdy_mask_reg    <= RDY_MASK_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_addr)
                CFG_START_ADDR:  start_addr_reg  <= cfg_data;
                CFG_MODE_ADDR:   mode_addr_reg   <= cfg_data;
                CFG_MODE_VALUE:  mode_value_reg  <= cfg_data;
                CFG_RESULT_ADDR: result_addr_reg <= cfg_data;
                CFG_ERR_MASK:    err_mask_reg    <= cfg_data;
                CFG_RDY_MASK:    rdy_mask_reg    <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eco2_reg   <= '0;
            tvoc_reg   <= '0;
            cur_reg    <= '0;
            adc_reg    <= '0;
            res_reg    <= '0;
            status_reg <= '0;
        end
        else
        begin
            if (cmd.latch_status)
            begin
                status_reg <= in_status;
            end
            if (cmd.latch_meas)
            begin
                eco2_reg <= in_eco2;
                tvoc_reg <= in_tvoc;
                cur_reg  <= in_raw[15:10];
                adc_reg  <= in_raw[9:0];
            end
            if (cmd.res_load)
            begin
                res_reg <= (cur_reg == 6'd0) ? RES_SAT : quot;
            end
        end
    end

    always_comb
    begin
        p_tx_len_next  = 2'd0;
        p_tx_reg_next  = 8'd0;
        p_tx_data_next = 8'd0;
        p_rx_len_next  = 4'd0;
        case (cmd.tx_kind)
            TX_START:
            begin
                p_tx_len_next = 2'd1;
                p_tx_reg_next = start_addr_reg;
            end
            TX_MODE:
            begin
                p_tx_len_next  = 2'd2;
                p_tx_reg_next  = mode_addr_reg;
                p_tx_data_next = mode_value_reg;
            end
            TX_READ:
            begin
                p_tx_len_next = 2'd1;
                p_tx_reg_next = result_addr_reg;
                p_rx_len_next = RESULT_BLOCK_LEN;
            end
            default: ;
        endcase
    end

    // pending result fields and arithmetic operands
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            p_tx_len_reg  <= p_tx_len_next;
            p_tx_reg_reg  <= p_tx_reg_next;
            p_tx_data_reg <= p_tx_data_next;
            p_rx_len_reg  <= p_rx_len_next;
            p_new_reg     <= cmd.new_data;
            p_err_reg     <= cmd.in_error;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= DVD_W'(RES_NUM) * DVD_W'(adc_reg);
            // 1023 * current
            dvs_reg  <= {cur_reg, 10'd0} - {10'd0, cur_reg};
        end
    end

    gsps_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (dvs_reg),
        .done     (div_done),
        .quotient (quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            m_tdata_reg <= {4'd0, p_err_reg, status_reg, res_reg, adc_reg, cur_reg,
                            tvoc_reg, eco2_reg, p_rx_len_reg, p_tx_data_reg,
                            p_tx_reg_reg, p_tx_len_reg};
            m_tuser_reg <= p_new_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

### design/gsps_ctrl.sv
// controller: sensor sequence state and per-item processing phases
// depends on gsps_pkg

module gsps_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 operation,
    input  logic [1:0]           xfer_outcome,
    input  gsps_pkg::gsps_stat_t stat,
    output gsps_pkg::gsps_cmd_t  cmd
);
    import gsps_pkg::*;

    typedef enum logic [5:0] {
        SEQ_HOLD      = 6'b000001,
        SEQ_BOOTED    = 6'b000010,
        SEQ_MODE_SENT = 6'b000100,
        SEQ_READING   = 6'b001000,
        SEQ_WAITING   = 6'b010000,
        SEQ_ERROR     = 6'b100000
    } seq_t;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_MUL    = 5'b00010,
        PH_DSTART = 5'b00100,
        PH_DIV    = 5'b01000,
        PH_LOAD   = 5'b10000
    } phase_t;

    seq_t   seq_reg, seq_next;
    phase_t phase_reg, phase_next;
    logic   acc;

    assign s_tready = (phase_reg == PH_IDLE);
    assign acc      = s_tvalid && s_tready;

    always_comb
    begin
        seq_next   = seq_reg;
        phase_next = phase_reg;
        cmd        = '0;
        cmd.tx_kind = TX_NONE;
        case (phase_reg)
            PH_IDLE:
            begin
                if (acc)
                begin
                    cmd.accept = 1'b1;
                    phase_next = PH_LOAD;
                    if (operation == OP_TICK)
                    begin
                        case (seq_reg)
                            SEQ_HOLD:
                            begin
                                cmd.tx_kind = TX_START;
                                seq_next    = SEQ_BOOTED;
                            end
                            SEQ_WAITING:
                            begin
                                cmd.tx_kind = TX_READ;
                                seq_next    = SEQ_READING;
                            end
                            default: ;
                        endcase
                    end
                    else if (xfer_outcome == XFER_OK)
                    begin
                        case (seq_reg)
                            SEQ_BOOTED:
                            begin
                                cmd.tx_kind = TX_MODE;
                                seq_next    = SEQ_MODE_SENT;
                            end
                            SEQ_MODE_SENT:
                            begin
                                cmd.tx_kind = TX_READ;
                                seq_next    = SEQ_READING;
                            end
                            SEQ_READING:
                            begin
                                cmd.latch_status = 1'b1;
                                // error bits win over ready bits
                                if (stat.err_hit)
                                begin
                                    seq_next = SEQ_ERROR;
                                end
                                else
                                begin
                                    seq_next = SEQ_WAITING;
                                    if (stat.rdy_hit)
                                    begin
                                        cmd.latch_meas = 1'b1;
                                        cmd.new_data   = 1'b1;
                                        phase_next     = PH_MUL;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                    else if (xfer_outcome == XFER_FAIL)
                    begin
                        if (seq_reg inside {SEQ_BOOTED, SEQ_MODE_SENT, SEQ_READING})
                        begin
                            seq_next = SEQ_ERROR;
                        end
                    end
                    cmd.in_error = (seq_next == SEQ_ERROR);
                end
            end
            PH_MUL:
            begin
                cmd.mul_en = 1'b1;
                phase_next = PH_DSTART;
            end
            PH_DSTART:
            begin
                cmd.div_start = 1'b1;
                phase_next    = PH_DIV;
            end
            PH_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.res_load = 1'b1;
                    phase_next   = PH_LOAD;
                end
            end
            PH_LOAD:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    phase_next   = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg   <= SEQ_HOLD;
            phase_reg <= PH_IDLE;
        end
        else
        begin
            seq_reg   <= seq_next;
            phase_reg <= phase_next;
        end
    end

endmodule

### design/gas_sensor_poll_sequencer.sv
// top level of the gas sensor poll sequencer
// depends on gsps_pkg, gsps_ctrl, gsps_dp (and gsps_div below it)

// Each input transfer is a period tick or a bus completion report and gives exactly one
// output transfer: the next bus command (tx_len 0 when none) plus the latest measurement.
// An item without a new measurement passes from its input transfer through the load phase
// into the output register, and no further input transfer is taken until that load is done.
// An item that latches new data passes through a multiply phase, a divider start phase, a
// 31-step restoring divider for 1650000*adc/(1023*current) at one quotient bit per cycle,
// a resistance load and the output register load before the input side is ready again.
// The input side is ready again as soon as the result sits in the output register, even
// if it has not been taken yet; the next item then waits only at its own output load.
// Configuration writes are always accepted; write them only while no item is in flight.

module gas_sensor_poll_sequencer (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // xfer_outcome[1:0], rx_eco2_word[17:2], rx_tvoc_word[33:18],
    // rx_status_byte[41:34], rx_raw_word[57:42], zero fill
    input  logic [gsps_pkg::S_TDATA_W-1:0]     s_tdata,
    // operation[0]
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // tx_len[1:0], tx_reg[9:2], tx_data[17:10], rx_len[21:18], eco2_ppm[37:22],
    // tvoc_ppb[53:38], heater_current[59:54], raw_adc[69:60], resistance_ohm[90:70],
    // sensor_status[98:91], in_error[99], zero fill
    output logic [gsps_pkg::M_TDATA_W-1:0]     m_tdata,
    // new_data[0]
    output logic                               m_tuser,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gsps_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [7:0]                         cfg_data
);
    import gsps_pkg::*;

    gsps_cmd_t  cmd;
    gsps_stat_t stat;

    assign cfg_ready = 1'b1;

    gsps_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .operation    (s_tuser),
        .xfer_outcome (s_tdata[1:0]),
        .stat         (stat),
        .cmd          (cmd)
    );

    gsps_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

### design/gsps_checker.sv
// port-level checks for the gas sensor poll sequencer, bound to the top level
// depends on gsps_pkg

module gsps_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [gsps_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tuser
);
    import gsps_pkg::*;

    logic err_seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_seen_reg <= 1'b0;
        end
        else if (m_tvalid && m_tready && m_tdata[99])
        begin
            err_seen_reg <= 1'b1;
        end
    end

    // error state is a trap
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && err_seen_reg |-> m_tdata[99])
        else $error("in_error dropped after being reported");

    // no transfer means all command fields are zero
    a_idle_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] == 2'd0) |->
            (m_tdata[9:2] == 8'd0) && (m_tdata[17:10] == 8'd0) && (m_tdata[21:18] == 4'd0))
        else $error("command fields set with no transfer");

    // a fresh measurement comes only from a completed read, which issues nothing
    a_new_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata[1:0] == 2'd0) && !m_tdata[99])
        else $error("new data together with a command or an error");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output transfer changed");

endmodule

bind gas_sensor_poll_sequencer gsps_checker u_gsps_checker (.*);

### bench/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for gas_sensor_poll_sequencer: feeds ticks and bus completion reports,
// predicts each result transfer and compares it field by field
// depends on gsps_pkg and the design sources of the block

module tb_top;
    import gsps_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int LONG_HOLD      = 300;
    localparam int PHASE_MOVES    = 300;

    localparam logic [1:0] XFER_IDLE = 2'd0;
    localparam logic [1:0] XFER_BAD  = 2'd3;
    localparam logic [1:0] LEN_ONE   = 2'd1;
    localparam logic [1:0] LEN_TWO   = 2'd2;

    typedef enum logic [2:0] {
        SEQ_HOLD      = 3'd0,
        SEQ_UNINIT    = 3'd1,
        SEQ_BOOTED    = 3'd2,
        SEQ_MODE_SENT = 3'd3,
        SEQ_READING   = 3'd4,
        SEQ_WAITING   = 3'd5,
        SEQ_ERROR     = 3'd6
    } seq_state_t;

    typedef struct packed {
        logic        op;
        logic [1:0]  outcome;
        logic [15:0] eco2;
        logic [15:0] tvoc;
        logic [7:0]  status;
        logic [15:0] raw;
    } poll_item_t;

    typedef struct packed {
        logic [1:0]  tx_len;
        logic [7:0]  tx_reg;
        logic [7:0]  tx_data;
        logic [3:0]  rx_len;
        logic        new_data;
        logic [15:0] eco2;
        logic [15:0] tvoc;
        logic [5:0]  current;
        logic [9:0]  adc;
        logic [20:0] res;
        logic [7:0]  status;
        logic        in_error;
    } poll_report_t;

    typedef struct packed {
        seq_state_t  state;
        logic [15:0] eco2;
        logic [15:0] tvoc;
        logic [5:0]  current;
        logic [9:0]  adc;
        logic [20:0] res;
        logic [7:0]  status;
    } sensor_ctx_t;

    typedef struct packed {
        logic [7:0] start_addr;
        logic [7:0] mode_addr;
        logic [7:0] mode_value;
        logic [7:0] result_addr;
        logic [7:0] err_mask;
        logic [7:0] rdy_mask;
    } sensor_cfg_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [7:0]            cfg_data  = '0;

    poll_item_t   poll_queue[$];
    poll_report_t pending_reports[$];
    sensor_ctx_t  sensor_shadow;
    sensor_ctx_t  plan_shadow;
    sensor_cfg_t  cfg_shadow;

    int error_count    = 0;
    int idle_cycles    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    bit hold_request   = 1'b0;
    bit hold_done      = 1'b0;
    bit s_fire         = 1'b0;

    gas_sensor_poll_sequencer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [20:0] heater_resistance(input logic [9:0] adc,
                                                      input logic [5:0] current);
        logic [63:0] q;
        if (current == 6'd0)
            return RES_SAT;
        q = (64'd1650000 * 64'(adc)) / (64'd1023 * 64'(current));
        return (q > 64'(RES_SAT)) ? RES_SAT : q[20:0];
    endfunction

    // one sequencer step: updates the context and returns the result transfer
    function automatic poll_report_t advance_sequencer(inout sensor_ctx_t ctx,
                                                       input sensor_cfg_t cfg,
                                                       input poll_item_t it);
        poll_report_t r;
        r = '0;
        if (it.op == OP_TICK)
        begin
            if (ctx.state inside {SEQ_HOLD, SEQ_UNINIT})
            begin
                r.tx_len = LEN_ONE;
                r.tx_reg = cfg.start_addr;
                ctx.state = SEQ_BOOTED;
            end
            else if (ctx.state == SEQ_WAITING)
            begin
                r.tx_len = LEN_ONE;
                r.tx_reg = cfg.result_addr;
                r.rx_len = RESULT_BLOCK_LEN;
                ctx.state = SEQ_READING;
            end
        end
        else if (it.outcome == XFER_OK)
        begin
            case (ctx.state)
                SEQ_BOOTED:
                begin
                    r.tx_len = LEN_TWO;
                    r.tx_reg = cfg.mode_addr;
                    r.tx_data = cfg.mode_value;
                    ctx.state = SEQ_MODE_SENT;
                end
                SEQ_MODE_SENT:
                begin
                    r.tx_len = LEN_ONE;
                    r.tx_reg = cfg.result_addr;
                    r.rx_len = RESULT_BLOCK_LEN;
                    ctx.state = SEQ_READING;
                end
                SEQ_READING:
                begin
                    ctx.status = it.status;
                    // error bits win over ready bits
                    if ((it.status & cfg.err_mask) != 8'd0)
                        ctx.state = SEQ_ERROR;
                    else
                    begin
                        if ((it.status & cfg.rdy_mask) != 8'd0)
                        begin
                            ctx.eco2 = it.eco2;
                            ctx.tvoc = it.tvoc;
                            ctx.current = it.raw[15:10];
                            ctx.adc = it.raw[9:0];
                            ctx.res = heater_resistance(it.raw[9:0], it.raw[15:10]);
                            r.new_data = 1'b1;
                        end
                        ctx.state = SEQ_WAITING;
                    end
                end
                default: ;
            endcase
        end
        else if (it.outcome == XFER_FAIL)
        begin
            if (ctx.state inside {SEQ_BOOTED, SEQ_MODE_SENT, SEQ_READING})
                ctx.state = SEQ_ERROR;
        end
        r.eco2 = ctx.eco2;
        r.tvoc = ctx.tvoc;
        r.current = ctx.current;
        r.adc = ctx.adc;
        r.res = ctx.res;
        r.status = ctx.status;
        r.in_error = (ctx.state == SEQ_ERROR);
        return r;
    endfunction

    // queues an item and tracks the state it leads to; returns 1 if it did anything
    function automatic bit queue_item(input logic op, input logic [1:0] outcome,
                                      input logic [15:0] eco2, input logic [15:0] tvoc,
                                      input logic [7:0] status, input logic [15:0] raw);
        poll_item_t   it;
        poll_report_t r;
        seq_state_t   was;
        it.op = op;
        it.outcome = outcome;
        it.eco2 = eco2;
        it.tvoc = tvoc;
        it.status = status;
        it.raw = raw;
        was = plan_shadow.state;
        r = advance_sequencer(plan_shadow, cfg_shadow, it);
        poll_queue.push_back(it);
        return (plan_shadow.state != was) || r.new_data;
    endfunction

    // mostly items that move the sequence on, some noise; never trips the error state
    function automatic bit queue_random_item();
        logic [7:0]  status;
        logic [15:0] raw;
        int          pick;
        status = 8'($urandom);
        raw = 16'($urandom);
        pick = $urandom_range(99, 0);
        if (pick < 8)
            raw[15:10] = 6'd0;
        else if (pick < 12)
            raw = 16'hFFFF;
        else if (pick < 16)
            raw = 16'h0000;
        else if (pick < 20)
            raw[15:10] = 6'd1;
        pick = $urandom_range(99, 0);
        case (plan_shadow.state)
            SEQ_BOOTED, SEQ_MODE_SENT, SEQ_READING:
            begin
                status = status & ~cfg_shadow.err_mask;
                if ($urandom_range(99, 0) < 70)
                    status = status | (cfg_shadow.rdy_mask & ~cfg_shadow.err_mask);
                if (pick < 85)
                    return queue_item(OP_DONE, XFER_OK, 16'($urandom), 16'($urandom),
                                      status, raw);
                else if (pick < 92)
                    return queue_item(OP_TICK, 2'($urandom), 16'($urandom), 16'($urandom),
                                      status, raw);
                else
                    return queue_item(OP_DONE, pick[0] ? XFER_IDLE : XFER_BAD,
                                      16'($urandom), 16'($urandom), status, raw);
            end
            SEQ_ERROR:
                return queue_item(1'($urandom), 2'($urandom), 16'($urandom), 16'($urandom),
                                  status, raw);
            default:
            begin
                if (pick < 80)
                    return queue_item(OP_TICK, 2'($urandom), 16'($urandom), 16'($urandom),
                                      status, raw);
                else
                    return queue_item(OP_DONE, 2'($urandom_range(3, 0)), 16'($urandom),
                                      16'($urandom), status, raw);
            end
        endcase
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    task automatic wait_idle();
        while (poll_queue.size() != 0 || s_tvalid || pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_ADDR_W-1:0] idx, input logic [7:0] value);
        @(negedge clk);
        cfg_addr <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_START_ADDR:  cfg_shadow.start_addr = value;
            CFG_MODE_ADDR:   cfg_shadow.mode_addr = value;
            CFG_MODE_VALUE:  cfg_shadow.mode_value = value;
            CFG_RESULT_ADDR: cfg_shadow.result_addr = value;
            CFG_ERR_MASK:    cfg_shadow.err_mask = value;
            CFG_RDY_MASK:    cfg_shadow.rdy_mask = value;
            default: ;
        endcase
    endtask

    task automatic run_phase(input sensor_cfg_t c, input int send_pct, input int stall_pct);
        int moved;
        wait_idle();
        write_register(CFG_START_ADDR, c.start_addr);
        write_register(CFG_MODE_ADDR, c.mode_addr);
        write_register(CFG_MODE_VALUE, c.mode_value);
        write_register(CFG_RESULT_ADDR, c.result_addr);
        write_register(CFG_ERR_MASK, c.err_mask);
        write_register(CFG_RDY_MASK, c.rdy_mask);
        @(negedge clk);
        cfg_valid <= 1'b0;
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
        moved = 0;
        while (moved < PHASE_MOVES)
            moved += int'(queue_random_item());
    endtask

    // sender: a new item only once the current one has been taken
    always @(negedge clk)
    begin : item_driver
        poll_item_t it;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || s_fire)
        begin
            if (poll_queue.size() != 0 && $urandom_range(99, 0) >= send_idle_pct)
            begin
                it = poll_queue.pop_front();
                s_tuser <= it.op;
                s_tdata <= {6'd0, it.raw, it.status, it.tvoc, it.eco2, it.outcome};
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver: random stalls, plus one long hold-off when requested
    always @(negedge clk)
    begin : report_sink
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (hold_request && !hold_done)
        begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin : result_monitor
        poll_item_t   it;
        poll_report_t want;
        s_fire = rst_n && s_tvalid && s_tready;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_reports.size() == 0)
            begin
                $display("%0t: result transfer with nothing expected, expected none, actual %h",
                         $time, m_tdata);
                error_count++;
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("tx_len", 32'(want.tx_len), 32'(m_tdata[1:0]));
                check_field("tx_reg", 32'(want.tx_reg), 32'(m_tdata[9:2]));
                check_field("tx_data", 32'(want.tx_data), 32'(m_tdata[17:10]));
                check_field("rx_len", 32'(want.rx_len), 32'(m_tdata[21:18]));
                check_field("new_data", 32'(want.new_data), 32'(m_tuser));
                check_field("eco2_ppm", 32'(want.eco2), 32'(m_tdata[37:22]));
                check_field("tvoc_ppb", 32'(want.tvoc), 32'(m_tdata[53:38]));
                check_field("heater_current", 32'(want.current), 32'(m_tdata[59:54]));
                check_field("raw_adc", 32'(want.adc), 32'(m_tdata[69:60]));
                check_field("resistance_ohm", 32'(want.res), 32'(m_tdata[90:70]));
                check_field("sensor_status", 32'(want.status), 32'(m_tdata[98:91]));
                check_field("in_error", 32'(want.in_error), 32'(m_tdata[99]));
            end
        end
        if (s_fire)
        begin
            it.op = s_tuser;
            it.outcome = s_tdata[1:0];
            it.eco2 = s_tdata[17:2];
            it.tvoc = s_tdata[33:18];
            it.status = s_tdata[41:34];
            it.raw = s_tdata[57:42];
            pending_reports.push_back(advance_sequencer(sensor_shadow, cfg_shadow, it));
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        sensor_cfg_t c;
        sensor_shadow = '0;
        sensor_shadow.state = SEQ_HOLD;
        plan_shadow = sensor_shadow;
        cfg_shadow = {START_ADDR_RST, MODE_ADDR_RST, MODE_VALUE_RST, RESULT_ADDR_RST,
                      ERR_MASK_RST, RDY_MASK_RST};
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed walk through the sequence with the reset register values
        void'(queue_item(OP_DONE, XFER_OK, 16'h0000, 16'h0000, 8'h00, 16'h0000));
        void'(queue_item(OP_DONE, XFER_FAIL, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF));
        void'(queue_item(OP_TICK, XFER_IDLE, 16'h0000, 16'h0000, 8'h00, 16'h0000));
        void'(queue_item(OP_TICK, XFER_BAD, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF));
        void'(queue_item(OP_DONE, XFER_IDLE, 16'h1234, 16'h5678, 8'h08, 16'h0400));
        void'(queue_item(OP_DONE, XFER_BAD, 16'h1234, 16'h5678, 8'h08, 16'h0400));
        void'(queue_item(OP_DONE, XFER_OK, 16'h0000, 16'h0000, 8'h00, 16'h0000));
        void'(queue_item(OP_DONE, XFER_OK, 16'h0000, 16'h0000, 8'h00, 16'h0000));
        // zero heater current saturates the resistance
        void'(queue_item(OP_DONE, XFER_OK, 16'hFFFF, 16'hFFFF, 8'h08, 16'h03FF));
        void'(queue_item(OP_TICK, XFER_IDLE, 16'h0000, 16'h0000, 8'h00, 16'h0000));
        // current 1, full-scale adc: largest resistance
        void'(queue_item(OP_DONE, XFER_OK, 16'h0000, 16'h0000, 8'hFE, 16'h07FF));
        void'(queue_item(OP_TICK, XFER_IDLE, 16'h0000, 16'h0000, 8'h00, 16'h0000));
        // no ready bit: status latched, measurement kept
        void'(queue_item(OP_DONE, XFER_OK, 16'hA5C3, 16'h5A3C, 8'h00, 16'hFFFF));
        void'(queue_item(OP_TICK, XFER_IDLE, 16'h0000, 16'h0000, 8'h00, 16'h0000));
        void'(queue_item(OP_DONE, XFER_OK, 16'h0000, 16'hFFFF, 8'h08, 16'hFC00));
        void'(queue_item(OP_TICK, XFER_IDLE, 16'h0000, 16'h0000, 8'h00, 16'h0000));
        void'(queue_item(OP_DONE, XFER_OK, 16'hFFFF, 16'h0000, 8'hF8, 16'hFFFF));
        void'(queue_item(OP_DONE, XFER_FAIL, 16'h0000, 16'h0000, 8'h01, 16'h0000));
        void'(queue_item(OP_TICK, XFER_OK, 16'h0000, 16'h0000, 8'h00, 16'h0000));
        void'(queue_item(OP_TICK, XFER_FAIL, 16'h0000, 16'h0000, 8'h00, 16'h0000));
        void'(queue_item(OP_DONE, XFER_OK, 16'h8001, 16'h7FFE, 8'h88, 16'h8421));

        c = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF};
        run_phase(c, 0, 0);
        c = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
        run_phase(c, 71, 0);
        c = 48'({$urandom, $urandom});
        run_phase(c, 0, 71);
        c = 48'({$urandom, $urandom});
        run_phase(c, 8, 8);
        // sender at full rate against a long receiver hold-off
        hold_request = 1'b1;
        c = {START_ADDR_RST, MODE_ADDR_RST, MODE_VALUE_RST, RESULT_ADDR_RST,
             ERR_MASK_RST, RDY_MASK_RST};
        run_phase(c, 0, 0);
        c = {8'h5A, 8'hA5, 8'hC3, 8'h3C, 8'h81, 8'h7E};
        run_phase(c, 71, 71);

        // steer into a result read, then trip the error trap with error and ready bits
        while (plan_shadow.state != SEQ_READING)
            void'(queue_item((plan_shadow.state inside {SEQ_BOOTED, SEQ_MODE_SENT}) ?
                             OP_DONE : OP_TICK, XFER_OK, 16'h0000, 16'h0000, 8'h00, 16'h0000));
        void'(queue_item(OP_DONE, XFER_OK, 16'hBEEF, 16'hCAFE,
                         cfg_shadow.err_mask | cfg_shadow.rdy_mask, 16'h1234));
        repeat (40) void'(queue_random_item());

        wait_idle();
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### files.f
design/gsps_pkg.sv
design/gsps_div.sv
design/gsps_dp.sv
design/gsps_ctrl.sv
design/gas_sensor_poll_sequencer.sv
design/gsps_checker.sv
bench/tb_top.sv
